>>> rtl/core/priority_task_sorter_unit_macros.svh
// assertion macros for the priority task sorter checker
// needs clk and arst_n in the scope where a macro is used
`ifndef PRIORITY_TASK_SORTER_UNIT_MACROS_SVH
`define PRIORITY_TASK_SORTER_UNIT_MACROS_SVH

// same-cycle implication, reset masks the check
`define PTS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, reset masks the check
`define PTS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/core/pts_pkg.sv
// shared types and constants of the priority task sorter
// no dependencies
`default_nettype none

package pts_pkg;

	localparam int PRIO_W   = 16;
	localparam int HANDLE_W = 32;
	localparam int CAP_W    = 5;

	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	localparam logic REQ_REGISTER = 1'b0;
	localparam logic REQ_EXECUTE  = 1'b1;

	typedef struct packed {
		logic signed [PRIO_W-1:0] prio;
		logic [HANDLE_W-1:0]      handle;
	} entry_t;

endpackage

`default_nettype wire

>>> rtl/core/pts_store.sv
// task table memory: one write port, one read port with registered data
// depends on pts_pkg
`default_nettype none

module pts_store #(
	parameter int DEPTH = 16,
	parameter int AW    = 4
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [AW-1:0]     waddr,
	input  wire pts_pkg::entry_t   wdata,
	input  wire logic              re,
	input  wire logic [AW-1:0]     raddr,
	output pts_pkg::entry_t        rdata
);

	pts_pkg::entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/pts_seq.sv
// sequencer of the priority task sorter: insertion by backward shift and
// in-order readout, one signed compare unit, output register
// depends on pts_pkg and pts_store
`default_nettype none

module pts_seq #(
	parameter int MAX_TASKS = 16,
	parameter int AW        = 4,
	parameter int CW        = 5
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic [pts_pkg::CAP_W-1:0]     capacity,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic                          in_req,
	input  wire pts_pkg::entry_t               in_entry,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output pts_pkg::entry_t                    out_entry,
	output logic                               out_last
);

	localparam int LW = (CW > pts_pkg::CAP_W) ? CW : pts_pkg::CAP_W;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_INS_CMP,
		ST_INS_PUT,
		ST_EX_LOAD
	} state_t;

	state_t          state_q;
	logic [CW-1:0]   count_q;
	logic [CW-1:0]   k_q;
	logic [CW-1:0]   i_q;
	pts_pkg::entry_t new_q;
	logic            out_valid_q;
	pts_pkg::entry_t out_entry_q;
	logic            out_last_q;

	logic            we;
	logic [AW-1:0]   waddr;
	pts_pkg::entry_t wdata;
	logic            re;
	logic [AW-1:0]   raddr;
	pts_pkg::entry_t rdata;

	logic            accept;
	logic            full;
	logic            less;
	logic            out_free;
	logic            load_out;
	logic            is_last;
	logic [CW-1:0]   cnt_m1;
	logic [CW-1:0]   cnt_p1;
	logic [CW-1:0]   k_m1;
	logic [CW-1:0]   k_m2;
	logic [CW-1:0]   i_p1;

	pts_store #(
		.DEPTH (MAX_TASKS),
		.AW    (AW)
	) u_store (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign full      = (LW'(count_q) >= LW'(capacity)) || (count_q == CW'(MAX_TASKS));
	assign cnt_m1    = count_q - CW'(1);
	assign cnt_p1    = count_q + CW'(1);
	assign k_m1      = k_q - CW'(1);
	assign k_m2      = k_q - CW'(2);
	assign i_p1      = i_q + CW'(1);
	assign is_last   = (i_q == cnt_m1);
	assign out_free  = !out_valid_q || out_ready;
	assign load_out  = (state_q == ST_EX_LOAD) && out_free;
	// the shared compare: stored entry moves up while it ranks below the new one
	assign less      = $signed(rdata.prio) < $signed(new_q.prio);

	assign out_valid = out_valid_q;
	assign out_entry = out_entry_q;
	assign out_last  = out_last_q;

	always_comb begin
		we    = 1'b0;
		waddr = k_q[AW-1:0];
		wdata = new_q;
		re    = 1'b0;
		raddr = '0;
		case (state_q)
			ST_IDLE: begin
				if (accept && in_req == pts_pkg::REQ_REGISTER && !full) begin
					if (count_q == '0) begin
						we    = 1'b1;
						waddr = '0;
						wdata = in_entry;
					end else begin
						re    = 1'b1;
						raddr = cnt_m1[AW-1:0];
					end
				end else if (accept && in_req == pts_pkg::REQ_EXECUTE && count_q != '0) begin
					re    = 1'b1;
					raddr = '0;
				end
			end
			ST_INS_CMP: begin
				we = 1'b1;
				if (less) begin
					wdata = rdata;
					if (k_q != CW'(1)) begin
						re    = 1'b1;
						raddr = k_m2[AW-1:0];
					end
				end
			end
			ST_INS_PUT: begin
				we = 1'b1;
			end
			ST_EX_LOAD: begin
				if (out_free && !is_last) begin
					re    = 1'b1;
					raddr = i_p1[AW-1:0];
				end
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			k_q         <= '0;
			i_q         <= '0;
			new_q       <= '0;
			out_valid_q <= 1'b0;
			out_entry_q <= '0;
			out_last_q  <= 1'b0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept && in_req == pts_pkg::REQ_REGISTER && !full) begin
						new_q <= in_entry;
						if (count_q == '0) begin
							count_q <= cnt_p1;
						end else begin
							k_q     <= count_q;
							state_q <= ST_INS_CMP;
						end
					end else if (accept && in_req == pts_pkg::REQ_EXECUTE && count_q != '0) begin
						i_q     <= '0;
						state_q <= ST_EX_LOAD;
					end
				end
				ST_INS_CMP: begin
					if (less) begin
						k_q <= k_m1;
						if (k_q == CW'(1)) begin
							state_q <= ST_INS_PUT;
						end
					end else begin
						count_q <= cnt_p1;
						state_q <= ST_IDLE;
					end
				end
				ST_INS_PUT: begin
					count_q <= cnt_p1;
					state_q <= ST_IDLE;
				end
				ST_EX_LOAD: begin
					if (out_free) begin
						out_entry_q <= rdata;
						out_last_q  <= is_last;
						if (is_last) begin
							state_q <= ST_IDLE;
						end else begin
							i_q <= i_p1;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/priority_task_sorter_unit.sv
// channel   dir  handshake                    payload
// request   in   s_axis_tvalid/s_axis_tready  tuser: req_type; tdata: priority, handle
// result    out  m_axis_tvalid/m_axis_tready  tdata: handle, priority; tlast: last
// config    in   cfg_we                       cfg_wdata: capacity_in_use
//
// register request: written directly into an empty table, else each lower-priority entry
// is moved down in turn, paced by the single memory read port and the compare unit
// execute request: the first entry is fetched, then one result per cycle while
// m_axis_tready is high; s_axis_tready stays low until the last result is loaded
// reset leaves the table empty and capacity 16; stalls hold the output register
//
// top level of the priority task sorter; depends on pts_pkg, pts_seq
`default_nettype none

module priority_task_sorter_unit #(
	parameter int MAX_TASKS = 16
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        s_axis_tvalid,
	output logic                             s_axis_tready,
	// [15:0] priority_req, [47:16] task_handle
	input  wire logic [47:0]                 s_axis_tdata,
	// [0] req_type
	input  wire logic [0:0]                  s_axis_tuser,
	output logic                             m_axis_tvalid,
	input  wire logic                        m_axis_tready,
	// [31:0] task_handle_out, [47:32] priority_out
	output logic [47:0]                      m_axis_tdata,
	output logic                             m_axis_tlast,
	input  wire logic                        cfg_we,
	input  wire logic [pts_pkg::CAP_W-1:0]   cfg_wdata
);

	localparam int AW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
	localparam int CW = $clog2(MAX_TASKS + 1);

	logic [pts_pkg::CAP_W-1:0] cap_q;
	pts_pkg::entry_t           in_entry;
	pts_pkg::entry_t           out_entry;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= pts_pkg::CAP_RESET;
		end else if (cfg_we) begin
			cap_q <= cfg_wdata;
		end
	end

	assign in_entry.prio   = s_axis_tdata[15:0];
	assign in_entry.handle = s_axis_tdata[47:16];

	pts_seq #(
		.MAX_TASKS (MAX_TASKS),
		.AW        (AW),
		.CW        (CW)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.capacity  (cap_q),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_req    (s_axis_tuser[0]),
		.in_entry  (in_entry),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_entry (out_entry),
		.out_last  (m_axis_tlast)
	);

	assign m_axis_tdata = {out_entry.prio, out_entry.handle};

endmodule

`default_nettype wire

>>> rtl/core/pts_checker.sv
// port-level checks of the priority task sorter, bound to the top level
// depends on priority_task_sorter_unit_macros.svh
`default_nettype none
`include "priority_task_sorter_unit_macros.svh"

module pts_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_axis_tready,
	input wire logic        m_axis_tvalid,
	input wire logic        m_axis_tready,
	input wire logic [47:0] m_axis_tdata,
	input wire logic        m_axis_tlast
);

	// a stalled result keeps its payload
	`PTS_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "stalled result changed")

	// no request is taken in the middle of an execute run
	`PTS_ASSERT_NOW(a_run_busy, m_axis_tvalid && !m_axis_tlast, !s_axis_tready, "request taken mid-run")

	// a run only starts while the sequencer is busy
	`PTS_ASSERT_NOW(a_run_start, $rose(m_axis_tvalid), !$past(s_axis_tready), "result without execute")

endmodule

bind priority_task_sorter_unit pts_checker u_pts_checker (.*);

`default_nettype wire
